### design/sparse_index_set_macros.svh
// ----------------------------------------------------------------------------
// Sparse index set assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SPARSE_INDEX_SET_MACROS_SVH
`define SPARSE_INDEX_SET_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SIS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// A condition that must be followed in the next cycle by a consequence.
`define SIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sis_pkg.sv
// ----------------------------------------------------------------------------
// Sparse index set package
// Field widths, operation and status codes, controller states and the
// result beat layout of the sparse index set.
// ----------------------------------------------------------------------------
`default_nettype none

package sis_pkg;

  // Field widths of the input and result beats.
  localparam int KindW   = 3;
  localparam int ElemW   = 10;
  localparam int SlotW   = 10;
  localparam int StatW   = 2;
  localparam int CountW  = 11;
  localparam int InDataW  = 24;
  localparam int OutDataW = 40;

  // Number of distinct values an element field can carry.
  localparam int ElemSpan = 1 << ElemW;

  // Operation codes carried in tuser.
  typedef enum logic [KindW-1:0] {
    KIND_INSERT = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_CLEAR  = 3'd2,
    KIND_QUERY  = 3'd3,
    KIND_READ   = 3'd4
  } kind_t;

  // Result status codes.
  typedef enum logic [StatW-1:0] {
    STAT_DONE     = 2'd0,
    STAT_NOCHANGE = 2'd1,
    STAT_BEYOND   = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_LOOK,
    S_DEL2,
    S_CLR
  } state_t;

  // Position table entry: a valid mark and the slot in the member list.
  typedef struct packed {
    logic             valid;
    logic [SlotW-1:0] slot;
  } pos_entry_t;

  // Result beat, first field in the highest bits.
  typedef struct packed {
    logic [CountW-1:0] member_count;
    logic [ElemW-1:0]  member_value;
    logic [SlotW-1:0]  slot;
    logic              is_member;
    status_t           status;
  } result_t;

endpackage

`default_nettype wire

### design/sparse_index_set.sv
// ----------------------------------------------------------------------------
// Sparse index set
// A set of small integer indices held as a position table and a packed
// member list in two synchronous memories, one operation per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_axis_*: tuser carries the operation (insert,
//   delete, clear all, membership query, read member at position), tdata
//   carries the element and the position. Every input beat produces exactly
//   one result beat on m_axis_*.
//   Insert, query and read first read both memories through their registered
//   read ports, then update them and load the output register. Delete adds a
//   further update step, because the position table has one write port and
//   needs two writes. Clear all walks the member list through its read port,
//   emptying each member's position table entry, and then loads its result.
//   A new beat is accepted as soon as the previous operation has loaded its
//   result, even while that result still waits in the output register.
//   If the receiver stalls and the output register is still full, the
//   operation holds before its first update until the register drains; a
//   clear walk runs on and holds only before loading its result.
//   After reset the block sweeps all min(LIMIT, 1024) position table entries,
//   one entry per cycle; s_axis_tready stays low during the sweep.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sparse_index_set_macros.svh"

module sparse_index_set #(
  parameter int LIMIT = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output      logic                        s_axis_tready,
  // [9:0] element, [19:10] position, rest zero
  input  wire logic [sis_pkg::InDataW-1:0] s_axis_tdata,
  // [2:0] kind
  input  wire logic [sis_pkg::KindW-1:0]   s_axis_tuser,
  output      logic                        m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [1:0] status, [2] is_member, [12:3] slot, [22:13] member_value,
  // [33:23] member_count, rest zero
  output      logic [sis_pkg::OutDataW-1:0] m_axis_tdata
);
  import sis_pkg::*;

  // Table depth: elements beyond the element field cannot occur.
  localparam int DEPTH = (LIMIT < ElemSpan) ? LIMIT : ElemSpan;
  localparam int AW    = $clog2(DEPTH);

  // Input beat fields.
  logic [ElemW-1:0] s_element;
  logic [ElemW-1:0] s_position;
  kind_t            s_kind;
  logic             s_in_range;

  assign s_element  = s_axis_tdata[ElemW-1:0];
  assign s_position = s_axis_tdata[2*ElemW-1:ElemW];
  assign s_kind     = kind_t'(s_axis_tuser);
  assign s_in_range = int'(s_element) < LIMIT;

  // Control state.
  state_t            state, state_next;
  logic [CountW-1:0] count, count_next;
  logic [AW-1:0]     init_idx;
  logic [CountW-1:0] clr_idx, clr_idx_next;
  logic              clr_pend, clr_pend_next;

  // Operation registers.
  kind_t             op_kind;
  logic [ElemW-1:0]  op_elem;
  logic [ElemW-1:0]  op_pos;
  logic              op_in_range;

  // Memory ports.
  pos_entry_t        pos_mem [DEPTH];
  logic              pos_rd_en;
  logic [AW-1:0]     pos_rd_addr;
  pos_entry_t        pos_rdata;
  logic              pos_we;
  logic [AW-1:0]     pos_wr_addr;
  pos_entry_t        pos_wdata;

  logic [ElemW-1:0]  mem_list [DEPTH];
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [ElemW-1:0]  mem_rdata;
  logic              mem_we;
  logic [AW-1:0]     mem_wr_addr;
  logic [ElemW-1:0]  mem_wdata;

  // Result path.
  result_t           res;
  logic              res_load;
  result_t           out_res;
  logic              out_free;

  logic [CountW-1:0] count_m1;
  logic              accept;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign count_m1 = count - CountW'(1);

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = OutDataW'(out_res);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (init_idx == AW'(DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = (s_kind == KIND_CLEAR) ? S_CLR : S_LOOK;
      end
      S_LOOK: begin
        if (out_free) begin
          if (op_kind == KIND_DELETE && op_in_range && pos_rdata.valid &&
              count != '0) begin
            state_next = S_DEL2;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_DEL2: begin
        if (out_free) state_next = S_IDLE;
      end
      S_CLR: begin
        if (clr_idx >= count && !clr_pend && out_free) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  // Datapath control: memory accesses, count update and result.
  always_comb begin
    pos_rd_en     = 1'b0;
    pos_rd_addr   = s_element[AW-1:0];
    pos_we        = 1'b0;
    pos_wr_addr   = init_idx;
    pos_wdata     = '0;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = count_m1[AW-1:0];
    mem_we        = 1'b0;
    mem_wr_addr   = count[AW-1:0];
    mem_wdata     = op_elem;
    count_next    = count;
    clr_idx_next  = clr_idx;
    clr_pend_next = clr_pend;
    res_load      = 1'b0;
    res           = '0;

    unique case (state)
      S_INIT: begin
        // Sweep the position table to the empty mark.
        pos_we = 1'b1;
      end

      S_IDLE: begin
        // Read the element's entry and the member that the operation needs.
        clr_idx_next  = '0;
        clr_pend_next = 1'b0;
        if (accept) begin
          pos_rd_en   = 1'b1;
          mem_rd_en   = 1'b1;
          mem_rd_addr = (s_kind == KIND_READ) ? s_position[AW-1:0]
                                              : count_m1[AW-1:0];
        end
      end

      S_LOOK: begin
        if (out_free) begin
          res.status = STAT_NOCHANGE;
          res_load   = 1'b1;
          unique case (op_kind)
            KIND_INSERT: begin
              if (op_in_range && pos_rdata.valid) begin
                res.is_member = 1'b1;
                res.slot      = pos_rdata.slot;
              end else if (op_in_range && count < CountW'(DEPTH)) begin
                // Append at the end of the member list.
                pos_we          = 1'b1;
                pos_wr_addr     = op_elem[AW-1:0];
                pos_wdata.valid = 1'b1;
                pos_wdata.slot  = count[SlotW-1:0];
                mem_we          = 1'b1;
                count_next      = count + CountW'(1);
                res.status      = STAT_DONE;
                res.is_member   = 1'b1;
                res.slot        = count[SlotW-1:0];
              end
            end
            KIND_DELETE: begin
              if (op_in_range && pos_rdata.valid && count != '0) begin
                // Move the last member into the freed slot; result follows.
                res_load = 1'b0;
                if ((CountW'(pos_rdata.slot) + CountW'(1)) < count) begin
                  pos_we          = 1'b1;
                  pos_wr_addr     = mem_rdata[AW-1:0];
                  pos_wdata.valid = 1'b1;
                  pos_wdata.slot  = pos_rdata.slot;
                  mem_we          = 1'b1;
                  mem_wr_addr     = pos_rdata.slot[AW-1:0];
                  mem_wdata       = mem_rdata;
                end
              end
            end
            KIND_QUERY: begin
              if (op_in_range) begin
                res.status = STAT_DONE;
                if (pos_rdata.valid) begin
                  res.is_member = 1'b1;
                  res.slot      = pos_rdata.slot;
                end
              end
            end
            KIND_READ: begin
              if (CountW'(op_pos) < count) begin
                res.status       = STAT_DONE;
                res.member_value = mem_rdata;
              end else begin
                res.status = STAT_BEYOND;
              end
            end
            default: begin
              res.status = STAT_NOCHANGE;
            end
          endcase
        end
      end

      S_DEL2: begin
        // Empty the deleted element's entry and shrink the list.
        if (out_free) begin
          pos_we      = 1'b1;
          pos_wr_addr = op_elem[AW-1:0];
          count_next  = count_m1;
          res.status  = STAT_DONE;
          res_load    = 1'b1;
        end
      end

      S_CLR: begin
        // Read one member a cycle and empty its entry in the cycle after.
        if (clr_pend) begin
          pos_we      = 1'b1;
          pos_wr_addr = mem_rdata[AW-1:0];
        end
        if (clr_idx < count) begin
          mem_rd_en     = 1'b1;
          mem_rd_addr   = clr_idx[AW-1:0];
          clr_idx_next  = clr_idx + CountW'(1);
          clr_pend_next = 1'b1;
        end else begin
          clr_pend_next = 1'b0;
          if (!clr_pend && out_free) begin
            count_next = '0;
            res.status = STAT_DONE;
            res_load   = 1'b1;
          end
        end
      end

      default: begin
        pos_we = 1'b0;
      end
    endcase

    res.member_count = count_next;
  end

  // Position table memory.
  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wr_addr] <= pos_wdata;
    if (pos_rd_en) pos_rdata <= pos_mem[pos_rd_addr];
  end

  // Member list memory.
  always_ff @(posedge clk) begin
    if (mem_we) mem_list[mem_wr_addr] <= mem_wdata;
    if (mem_rd_en) mem_rdata <= mem_list[mem_rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      init_idx      <= '0;
      count         <= '0;
      clr_idx       <= '0;
      clr_pend      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      clr_idx  <= clr_idx_next;
      clr_pend <= clr_pend_next;
      if (state == S_INIT) init_idx <= init_idx + AW'(1);
      if (res_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Operation and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind     <= s_kind;
      op_elem     <= s_element;
      op_pos      <= s_position;
      op_in_range <= s_in_range;
    end
    if (res_load) out_res <= res;
  end

  // Checks on the set bookkeeping.
  `SIS_ASSERT(a_count_bound, count <= CountW'(DEPTH), "member count exceeds table depth")
  `SIS_ASSERT_NEXT(a_clr_count_hold, state == S_CLR && state_next == S_CLR, $stable(count), "count changed during clear walk")
  `SIS_ASSERT_NEXT(a_del_shrink, state == S_DEL2 && out_free, count == $past(count) - CountW'(1), "delete did not shrink count by one")
  `SIS_ASSERT(a_load_free, !(res_load && !out_free), "result loaded over a waiting beat")

endmodule

`default_nettype wire

### verif/sparse_index_set_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse index set testbench
// Drives insert, delete, clear, query, read and undefined operations into the
// stream input, tracks the expected set contents in a shadow copy and checks
// every result beat field by field, under three sender and receiver stall
// patterns.
// ----------------------------------------------------------------------------

module sparse_index_set_test;
  import sis_pkg::*;

  // Cycle budget for the whole run, including the position table sweep
  // after reset.
  localparam int CycleLimit = 400000;

  // Settling time after the last result.
  localparam int DrainCycles = 40;

  // Shadow copy of the set; predicts one result beat per accepted operation.
  class member_tracker;
    bit             present [ElemSpan];
    bit [SlotW-1:0] slot_of [ElemSpan];
    bit [ElemW-1:0] members [ElemSpan];
    int unsigned    count;
    result_t        answers_due[$];
    int             mismatches;

    // Applies one accepted operation and queues the result it must produce.
    function void apply_op(logic [KindW-1:0] op, logic [ElemW-1:0] elem,
                           logic [SlotW-1:0] pos);
      result_t     r;
      int unsigned d;
      bit [ElemW-1:0] tail;
      r = '0;
      r.status = STAT_DONE;
      case (op)
        KIND_INSERT: begin
          if (present[elem]) begin
            r.status = STAT_NOCHANGE;
            r.is_member = 1'b1;
            r.slot = slot_of[elem];
          end else if (count < ElemSpan) begin
            present[elem] = 1'b1;
            slot_of[elem] = count[SlotW-1:0];
            members[count] = elem;
            r.is_member = 1'b1;
            r.slot = count[SlotW-1:0];
            count++;
          end else begin
            r.status = STAT_NOCHANGE;
          end
        end
        KIND_DELETE: begin
          if (!present[elem] || count == 0) begin
            r.status = STAT_NOCHANGE;
          end else begin
            // The last member fills the freed slot.
            d = slot_of[elem];
            if (d + 1 < count) begin
              tail = members[count - 1];
              slot_of[tail] = d[SlotW-1:0];
              members[d] = tail;
            end
            present[elem] = 1'b0;
            slot_of[elem] = '0;
            count--;
          end
        end
        KIND_CLEAR: begin
          for (int i = 0; i < count; i++) begin
            present[members[i]] = 1'b0;
            slot_of[members[i]] = '0;
          end
          count = 0;
        end
        KIND_QUERY: begin
          if (present[elem]) begin
            r.is_member = 1'b1;
            r.slot = slot_of[elem];
          end
        end
        KIND_READ: begin
          if (pos < count) begin
            r.member_value = members[pos];
          end else begin
            r.status = STAT_BEYOND;
          end
        end
        default: begin
          r.status = STAT_NOCHANGE;
        end
      endcase
      r.member_count = count[CountW-1:0];
      answers_due.push_back(r);
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // Checks one result beat against the oldest prediction.
    function void check_answer(logic [OutDataW-1:0] beat);
      result_t got;
      result_t want;
      got = result_t'(beat[$bits(result_t)-1:0]);
      if (answers_due.size() == 0) begin
        $error("result beat %h arrived with no operation pending", beat);
        mismatches++;
        return;
      end
      want = answers_due.pop_front();
      compare("status", want.status, got.status);
      compare("is_member", want.is_member, got.is_member);
      compare("slot", want.slot, got.slot);
      compare("member_value", want.member_value, got.member_value);
      compare("member_count", want.member_count, got.member_count);
      compare("padding", '0, beat[OutDataW-1:$bits(result_t)]);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata = '0;
  logic [KindW-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;

  member_tracker tracker = new();
  int            tx_idle_pct = 0;
  int            rx_idle_pct = 0;
  int            cycles = 0;

  sparse_index_set i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  // Receiver: random back-pressure at the current stall rate.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Every accepted result beat is checked against the shadow set.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      tracker.check_answer(m_axis_tdata);
    end
  end

  // Run time guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("sparse_index_set_test: errors");
      $finish;
    end
  end

  // Sends one operation beat, with random idle cycles ahead of it, and records
  // it in the shadow set once s_axis_tready reads high after the beat is driven.
  task automatic send_op(input logic [KindW-1:0] op, input logic [ElemW-1:0] elem,
                         input logic [SlotW-1:0] pos);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(InDataW - ElemW - SlotW){1'b0}}, pos, elem};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tracker.apply_op(op, elem, pos);
  endtask

  // Holds the input idle until every predicted result has come back.
  task automatic wait_drained();
    if (tracker.answers_due.size() != 0) begin
      s_axis_tvalid <= 1'b0;
      while (tracker.answers_due.size() != 0) @(posedge clk);
    end
  endtask

  // Random operations biased toward current members and a narrow element
  // window, so that hits, moves on delete and duplicate inserts are common.
  task automatic run_phase(input int n, input int tx_pct, input int rx_pct);
    int unsigned     window_base;
    int unsigned     pick;
    logic [KindW-1:0] op;
    logic [ElemW-1:0] elem;
    logic [SlotW-1:0] pos;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    window_base = $urandom_range(ElemSpan - 64);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 36) op = KIND_INSERT;
      else if (pick < 60) op = KIND_DELETE;
      else if (pick < 78) op = KIND_QUERY;
      else if (pick < 90) op = KIND_READ;
      else if (pick < 93) op = KIND_CLEAR;
      else op = KindW'(KIND_READ + 1 + $urandom_range(2));

      pick = $urandom_range(99);
      if (pick < 45 && tracker.count > 0)
        elem = tracker.members[$urandom_range(tracker.count - 1)];
      else if (pick < 85)
        elem = ElemW'(window_base + $urandom_range(63));
      else
        elem = ElemW'($urandom_range(ElemSpan - 1));

      if ($urandom_range(99) < 70)
        pos = SlotW'($urandom_range(tracker.count));
      else
        pos = SlotW'($urandom_range(ElemSpan - 1));

      send_op(op, elem, pos);
      // Now and then the sender waits for the output to empty completely.
      if ($urandom_range(199) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty set, field extremes, duplicates, moves and bad kinds.
    send_op(KIND_READ, 10'd0, 10'd0);
    send_op(KIND_READ, 10'd1023, 10'd1023);
    send_op(KIND_QUERY, 10'd0, 10'd0);
    send_op(KIND_DELETE, 10'd1023, 10'd0);
    send_op(KIND_CLEAR, 10'd0, 10'd0);
    send_op(KIND_INSERT, 10'd0, 10'd1023);
    send_op(KIND_INSERT, 10'd1023, 10'd0);
    send_op(KIND_INSERT, 10'd0, 10'd0);
    send_op(KIND_INSERT, 10'd682, 10'd341);
    send_op(KIND_INSERT, 10'd341, 10'd682);
    send_op(KIND_QUERY, 10'd1023, 10'd0);
    send_op(KIND_QUERY, 10'd0, 10'd0);
    send_op(KIND_READ, 10'd0, 10'd0);
    send_op(KIND_READ, 10'd0, 10'd3);
    send_op(KIND_READ, 10'd0, 10'd4);
    send_op(KIND_READ, 10'd0, 10'd1023);
    send_op(KIND_DELETE, 10'd0, 10'd0);
    send_op(KIND_DELETE, 10'd682, 10'd0);
    send_op(KIND_DELETE, 10'd0, 10'd0);
    send_op(KIND_READ + 3'd1, 10'd1023, 10'd1023);
    send_op(KIND_READ + 3'd2, 10'd0, 10'd0);
    send_op(KIND_READ + 3'd3, 10'd1023, 10'd1023);
    send_op(KIND_CLEAR, 10'd1023, 10'd1023);
    send_op(KIND_QUERY, 10'd341, 10'd0);
    send_op(KIND_READ, 10'd0, 10'd0);
    wait_drained();

    // Random: slow receiver, then slow sender, then full rate.
    run_phase(400, 26, 69);
    run_phase(400, 69, 26);
    run_phase(400, 0, 0);

    repeat (DrainCycles) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("sparse_index_set_test: clean");
    end else begin
      $display("sparse_index_set_test: errors");
    end
    $finish;
  end

endmodule
